// ===== rtl/wsjd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsjd_pkg: shared definitions for the work-stealing job dispatcher
// Field widths, operation codes and register reset values used by the
// interfaces and imported by every module of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wsjd_pkg;

    localparam int JOB_W = 16;
    localparam int WID_W = 2;
    localparam int CFG_W = 3;

    typedef logic [JOB_W-1:0] t_job;
    typedef logic [WID_W-1:0] t_wid;
    typedef logic [CFG_W-1:0] t_cfg;

    localparam logic OP_ASSIGN  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam t_cfg ACTIVE_RESET = 3'd2;

endpackage

`default_nettype wire

// ===== rtl/wsjd_if.sv =====
// ----------------------------------------------------------------------------
// wsjd_if: transaction channels of the work-stealing job dispatcher
// One interface for incoming work items and one for result items, each with
// a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsjd_in_if
    import wsjd_pkg::*;
    ();
    logic valid;
    logic ready;
    logic operation;
    t_job job_id;
    t_wid worker_id;

    modport source (output valid, output operation, output job_id, output worker_id,
                    input ready);
    modport sink   (input valid, input operation, input job_id, input worker_id,
                    output ready);
endinterface

interface wsjd_out_if
    import wsjd_pkg::*;
    ();
    logic valid;
    logic ready;
    logic job_valid;
    t_job job_out;
    t_wid source_worker;
    logic stolen;
    logic overflow;

    modport source (output valid, output job_valid, output job_out, output source_worker,
                    output stolen, output overflow, input ready);
    modport sink   (input valid, input job_valid, input job_out, input source_worker,
                    input stolen, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsjd_posu.sv =====
// ----------------------------------------------------------------------------
// wsjd_posu: circular slot position unit
// Adds an offset to a queue head and wraps the sum at the queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjd_posu
    import wsjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   i_base,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] i_off,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]   o_pos
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((PW > CW) ? PW : CW) + 1;

    logic [SW-1:0] s_sum;
    logic [SW-1:0] s_wrap;

    // Base and offset are each at most the depth, so one subtract suffices.
    always_comb begin
        s_sum  = SW'(i_base) + SW'(i_off);
        s_wrap = (s_sum >= SW'(QUEUE_DEPTH)) ? (s_sum - SW'(QUEUE_DEPTH)) : s_sum;
        o_pos  = s_wrap[PW-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/wsjd_mem.sv =====
// ----------------------------------------------------------------------------
// wsjd_mem: job slot memory
// Single-port store of job identifiers, one row of slots per worker, with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjd_mem
    import wsjd_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DEPTH  = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire t_job              i_wdata,
    output t_job                   o_rdata
);
    t_job r_mem [DEPTH];
    t_job r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/work_stealing_job_dispatcher.sv =====
// ----------------------------------------------------------------------------
// work_stealing_job_dispatcher: per-worker job deques with work stealing
// Top level: transaction sequencer, queue bookkeeping and result register.
// ----------------------------------------------------------------------------
// Each worker owns a circular deque of 16-bit job identifiers held in one
// shared slot memory. An assign transaction pushes its job onto the back of
// the worker picked by a round-robin pointer that wraps at the active worker
// count; a full deque drops the job and reports overflow. A request
// transaction pops the front of the requester's own deque; when that is empty
// (or the requester has no deque) the workers are scanned from 0 upward, one
// per cycle, and the back of the first nonempty active deque is popped and
// marked stolen. No job found gives an all-zero result. Exactly one result
// transaction is produced per input transaction. The block handles one item
// at a time. An assign passes S_LOOK, S_ADDR and S_DONE (S_LOOK and S_DONE
// alone when the deque is full); a request served from its own deque passes
// S_LOOK, S_ADDR, S_UPD and S_DONE; a request that steals stays in S_LOOK for
// each worker examined and then passes S_ADDR and S_DONE; one that finds none
// goes from S_LOOK to S_DONE. At most the active count of workers is examined,
// plus the requester's own deque when it was checked first. The sequencer
// walks the head/count table one worker per cycle, and the single memory port
// and the shared position adder serve the slot address and the head update
// in separate states. A result that is not taken holds the next item in its
// last state until the output register frees up. A finished result sits in
// an output register, so the next item is accepted while it waits. The user
// must write the active count through i_cfg_we/i_cfg_wdata only while idle;
// the block itself does not enforce this. 0 acts as 1 and values above
// NUM_WORKERS act as NUM_WORKERS. The slot memory needs no clearing: only
// slots inside a deque's live range are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_job_dispatcher
    import wsjd_pkg::*;
#(
    parameter int NUM_WORKERS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire t_cfg  i_cfg_wdata,
    wsjd_in_if.sink    i_in,
    wsjd_out_if.source o_out
);
    // Worker index, slot position, count and active-count widths.
    localparam int WW = $clog2(NUM_WORKERS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_WORKERS + 1);
    localparam int AD = WW + PW;
    localparam int MEM_DEPTH = NUM_WORKERS * (2 ** PW);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic          r_op, n_op;
    t_job          r_job, n_job;
    logic [WW-1:0] r_w, n_w;
    logic          r_steal, n_steal;
    logic [CW-1:0] r_off, n_off;
    logic          r_hit, n_hit;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_act, n_act;
    logic [WW-1:0] r_rr, n_rr;
    t_cfg          r_cfg;

    logic [PW-1:0] r_head [NUM_WORKERS];
    logic [CW-1:0] r_cnt  [NUM_WORKERS];

    logic          r_ovld;
    logic          r_o_job_valid;
    t_job          r_o_job_out;
    t_wid          r_o_source;
    logic          r_o_stolen;
    logic          r_o_overflow;

    logic [AW-1:0] s_act;
    logic [PW-1:0] s_head;
    logic [CW-1:0] s_cnt;
    logic [CW-1:0] s_pos_off;
    logic [PW-1:0] s_pos;
    logic [AD-1:0] s_addr;
    logic          s_mem_we;
    logic          s_mem_re;
    t_job          s_rdata;
    logic          s_cnt_we;
    logic [CW-1:0] s_cnt_new;
    logic          s_head_we;
    logic          s_accept;
    logic          s_load;
    logic          s_last;

    // Clamp the configured active count into 1..NUM_WORKERS.
    always_comb begin
        if (r_cfg == '0) begin
            s_act = AW'(1);
        end else if (32'(r_cfg) > NUM_WORKERS) begin
            s_act = AW'(NUM_WORKERS);
        end else begin
            s_act = AW'(r_cfg);
        end
    end

    // Bookkeeping of the worker currently under the sequencer.
    assign s_head = r_head[r_w];
    assign s_cnt  = r_cnt[r_w];
    assign s_last = (32'(r_w) + 1) >= 32'(r_act);

    // The position unit serves the slot address, and for a front pop it is
    // reused in the next cycle (S_UPD) to advance the head by one.
    assign s_pos_off = (r_state == S_UPD) ? CW'(1) : r_off;

    wsjd_posu #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_posu (
        .i_base(s_head),
        .i_off (s_pos_off),
        .o_pos (s_pos)
    );

    assign s_addr   = {r_w, s_pos};
    assign s_mem_we = (r_state == S_ADDR) && (r_op == OP_ASSIGN);
    assign s_mem_re = (r_state == S_ADDR) && (r_op == OP_REQUEST);

    wsjd_mem #(
        .ADDR_W(AD),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (s_mem_we),
        .i_re   (s_mem_re),
        .i_addr (s_addr),
        .i_wdata(r_job),
        .o_rdata(s_rdata)
    );

    assign s_cnt_we  = (r_state == S_ADDR);
    assign s_cnt_new = (r_op == OP_ASSIGN) ? (s_cnt + CW'(1)) : (s_cnt - CW'(1));
    assign s_head_we = (r_state == S_UPD);

    assign i_in.ready = (r_state == S_IDLE);
    assign s_accept   = i_in.valid && (r_state == S_IDLE);
    assign s_load     = (r_state == S_DONE) && (!r_ovld || o_out.ready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_job   = r_job;
        n_w     = r_w;
        n_steal = r_steal;
        n_off   = r_off;
        n_hit   = r_hit;
        n_ovf   = r_ovf;
        n_act   = r_act;
        n_rr    = r_rr;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op    = i_in.operation;
                    n_job   = i_in.job_id;
                    n_act   = s_act;
                    n_hit   = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = S_LOOK;
                    if (i_in.operation == OP_ASSIGN) begin
                        // A pointer left stale by a smaller active count restarts at 0.
                        n_w     = (32'(r_rr) >= 32'(s_act)) ? '0 : r_rr;
                        n_steal = 1'b0;
                    end else if (32'(i_in.worker_id) < NUM_WORKERS) begin
                        n_w     = WW'(i_in.worker_id);
                        n_steal = 1'b0;
                    end else begin
                        // No own deque: go straight to stealing.
                        n_w     = '0;
                        n_steal = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                if (r_op == OP_ASSIGN) begin
                    n_rr = s_last ? '0 : (r_w + WW'(1));
                    if (32'(s_cnt) >= QUEUE_DEPTH) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_off   = s_cnt;
                        n_state = S_ADDR;
                    end
                end else if (!r_steal) begin
                    if (s_cnt != '0) begin
                        n_off   = '0;
                        n_state = S_ADDR;
                    end else begin
                        n_steal = 1'b1;
                        n_w     = '0;
                    end
                end else begin
                    if (s_cnt != '0) begin
                        n_off   = s_cnt - CW'(1);
                        n_state = S_ADDR;
                    end else if (s_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_w = r_w + WW'(1);
                    end
                end
            end
            S_ADDR: begin
                if (r_op == OP_ASSIGN) begin
                    n_state = S_DONE;
                end else begin
                    n_hit   = 1'b1;
                    n_state = r_steal ? S_DONE : S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (s_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rr    <= '0;
            r_cfg   <= ACTIVE_RESET;
            r_hit   <= 1'b0;
            r_ovf   <= 1'b0;
            r_steal <= 1'b0;
            r_op    <= OP_ASSIGN;
            r_w     <= '0;
            r_act   <= AW'(1);
        end else begin
            r_state <= n_state;
            r_rr    <= n_rr;
            r_hit   <= n_hit;
            r_ovf   <= n_ovf;
            r_steal <= n_steal;
            r_op    <= n_op;
            r_w     <= n_w;
            r_act   <= n_act;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_off <= n_off;
    end

    // Head and count table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORKERS; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (s_cnt_we) begin
                r_cnt[r_w] <= s_cnt_new;
            end
            if (s_head_we) begin
                r_head[r_w] <= s_pos;
            end
        end
    end

    // Result register: an empty request reports worker 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (s_load) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_o_job_valid <= r_hit;
            r_o_job_out   <= r_hit ? s_rdata : '0;
            r_o_source    <= (r_hit || (r_op == OP_ASSIGN)) ? WID_W'(r_w) : '0;
            r_o_stolen    <= r_hit && r_steal;
            r_o_overflow  <= r_ovf;
        end
    end

    assign o_out.valid         = r_ovld;
    assign o_out.job_valid     = r_o_job_valid;
    assign o_out.job_out       = r_o_job_out;
    assign o_out.source_worker = r_o_source;
    assign o_out.stolen        = r_o_stolen;
    assign o_out.overflow      = r_o_overflow;

    // A pop is only ever issued against a deque that holds a job.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR && r_op == OP_REQUEST) |-> (s_cnt != '0))
        else $error("pop issued on an empty deque");

    // The deque under the sequencer never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(s_cnt) <= QUEUE_DEPTH)
        else $error("deque count above depth");

    // An accepted transaction always starts with the table lookup.
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_LOOK))
        else $error("accepted transaction did not start the lookup");

    // A stolen or dropped result is consistent with the job flag.
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((!o_out.stolen || o_out.job_valid)
                         && !(o_out.overflow && o_out.job_valid)))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire
